@@ hdl/ccc_pkg.sv @@
// ccc_pkg: request types, field limits, change codes and month length table
// for the calendar clock counter; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

    // one input request: a timer tick or a time load
    typedef struct packed {
        logic       operation;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } ccc_in_t;

    // one result request: full time plus event flags
    typedef struct packed {
        logic       second_event;
        logic [2:0] changed_field;
        logic [6:0] year_now;
        logic [3:0] month_now;
        logic [4:0] day_now;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       blink_led;
    } ccc_out_t;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // highest field changed by a second advance
    localparam logic [2:0] CHG_NONE   = 3'd0;
    localparam logic [2:0] CHG_SECOND = 3'd1;
    localparam logic [2:0] CHG_MINUTE = 3'd2;
    localparam logic [2:0] CHG_HOUR   = 3'd3;
    localparam logic [2:0] CHG_DAY    = 3'd4;
    localparam logic [2:0] CHG_MONTH  = 3'd5;
    localparam logic [2:0] CHG_YEAR   = 3'd6;

    // field limits
    localparam logic [5:0] SECOND_MAX = 6'd59;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [3:0] MONTH_MIN  = 4'd1;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] DAY_MIN    = 5'd1;
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] FEBRUARY   = 4'd2;
    localparam logic [4:0] LEAP_FEB   = 5'd29;

    // reset values
    localparam logic [7:0] PRESCALE_RESET = 8'd200;
    localparam logic [5:0] SECOND_RESET   = 6'd1;
    localparam logic [5:0] MINUTE_RESET   = 6'd1;
    localparam logic [4:0] HOUR_RESET     = 5'd14;
    localparam logic [4:0] DAY_RESET      = 5'd11;
    localparam logic [3:0] MONTH_RESET    = 4'd1;
    localparam logic [6:0] YEAR_RESET     = 7'd19;

    // days per month, index is the raw month code; unused codes read 31
    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    // month length with leap february on year mod 4 = 0
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [6:0] year);
        logic [4:0] len;
        len = MONTH_DAYS[month];
        if (month == FEBRUARY && year[1:0] == 2'b00)
        begin
            len = LEAP_FEB;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ hdl/calendar_clock_counter.sv @@
// calendar_clock_counter: tick prescaler and time/calendar counter with
// valid/stall request channels; depends on ccc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Real-time clock and calendar. Each input request is either one timer tick
// or a load of a new time; each produces exactly one result request carrying
// the full time, a second-event flag, the highest field that changed, and a
// blink level that toggles once per second. A prescaler counts ticks up to
// cfg_write_data (period is limit plus one, limit 0 makes every tick a
// second). Loaded fields are clamped to legal ranges, day against the loaded
// month and year. Throughput is one request per clock while out_stall is low:
// a request is captured in the input register, the whole rollover cascade
// (seconds through year, month length table lookup) resolves combinationally,
// and the time registers and the result register update together when the
// request advances, which also sets out_valid. The result register lets a new
// request enter while a finished result waits on out_stall. Write the
// prescale limit only while no request is in flight.
module calendar_clock_counter
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ccc_pkg::ccc_in_t  in_req,
    // result request channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ccc_pkg::ccc_out_t      out_req,
    // prescale limit register
    input  wire logic              cfg_write_en,
    input  wire logic [7:0]        cfg_write_data
);
    import ccc_pkg::*;

    // configuration
    logic [7:0] prescale_limit_reg;

    // input register
    logic       in_valid_reg;
    ccc_in_t    in_req_reg;

    // time state
    logic [7:0] tick_count_reg, tick_count_next;
    logic [5:0] second_reg,     second_next;
    logic [5:0] minute_reg,     minute_next;
    logic [4:0] hour_reg,       hour_next;
    logic [4:0] day_reg,        day_next;
    logic [3:0] month_reg,      month_next;
    logic [6:0] year_reg,       year_next;
    logic       led_reg,        led_next;

    // result register
    logic       out_valid_reg;
    ccc_out_t   out_req_reg, out_req_next;

    // handshake control
    logic       out_free;
    logic       advance;

    // scratch for the cascade
    logic [4:0] load_len;
    logic [4:0] cur_len;
    logic       sec_event;
    logic [2:0] changed;

    // result slot frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    // request in the input register is processed this cycle
    assign advance   = in_valid_reg && out_free;
    // hold off new requests only when the input register cannot drain
    assign in_stall  = in_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

    // single pass: load clamp or tick plus rollover cascade
    always_comb
    begin
        tick_count_next = tick_count_reg;
        second_next     = second_reg;
        minute_next     = minute_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        led_next        = led_reg;
        sec_event       = 1'b0;
        changed         = CHG_NONE;
        load_len        = 5'd0;
        cur_len         = month_length(month_reg, year_reg);

        if (in_req_reg.operation == OP_LOAD)
        begin
            // clamp each loaded field, day against the clamped month/year
            year_next = (in_req_reg.load_year > YEAR_MAX) ? YEAR_MAX
                                                          : in_req_reg.load_year;
            if (in_req_reg.load_month < MONTH_MIN)
            begin
                month_next = MONTH_MIN;
            end
            else if (in_req_reg.load_month > MONTH_MAX)
            begin
                month_next = MONTH_MAX;
            end
            else
            begin
                month_next = in_req_reg.load_month;
            end
            load_len = month_length(month_next, year_next);
            if (in_req_reg.load_day < DAY_MIN)
            begin
                day_next = DAY_MIN;
            end
            else if (in_req_reg.load_day > load_len)
            begin
                day_next = load_len;
            end
            else
            begin
                day_next = in_req_reg.load_day;
            end
            hour_next   = (in_req_reg.load_hour > HOUR_MAX) ? HOUR_MAX
                                                            : in_req_reg.load_hour;
            minute_next = (in_req_reg.load_minute > MINUTE_MAX) ? MINUTE_MAX
                                                                : in_req_reg.load_minute;
            second_next = (in_req_reg.load_second > SECOND_MAX) ? SECOND_MAX
                                                                : in_req_reg.load_second;
            tick_count_next = 8'd0;
        end
        else
        begin
            // prescaler wraps at or above the limit
            tick_count_next = (tick_count_reg < prescale_limit_reg)
                            ? tick_count_reg + 8'd1 : 8'd0;
            if (tick_count_next == prescale_limit_reg)
            begin
                sec_event = 1'b1;
                led_next  = !led_reg;
                if (second_reg < SECOND_MAX)
                begin
                    second_next = second_reg + 6'd1;
                    changed     = CHG_SECOND;
                end
                else if (minute_reg < MINUTE_MAX)
                begin
                    second_next = 6'd0;
                    minute_next = minute_reg + 6'd1;
                    changed     = CHG_MINUTE;
                end
                else if (hour_reg < HOUR_MAX)
                begin
                    second_next = 6'd0;
                    minute_next = 6'd0;
                    hour_next   = hour_reg + 5'd1;
                    changed     = CHG_HOUR;
                end
                else if (day_reg < cur_len)
                begin
                    second_next = 6'd0;
                    minute_next = 6'd0;
                    hour_next   = 5'd0;
                    day_next    = day_reg + 5'd1;
                    changed     = CHG_DAY;
                end
                else if (month_reg < MONTH_MAX)
                begin
                    second_next = 6'd0;
                    minute_next = 6'd0;
                    hour_next   = 5'd0;
                    day_next    = DAY_MIN;
                    month_next  = month_reg + 4'd1;
                    changed     = CHG_MONTH;
                end
                else
                begin
                    // december rolls into january of the next year
                    second_next = 6'd0;
                    minute_next = 6'd0;
                    hour_next   = 5'd0;
                    day_next    = DAY_MIN;
                    month_next  = MONTH_MIN;
                    year_next   = (year_reg < YEAR_MAX) ? year_reg + 7'd1 : 7'd0;
                    changed     = CHG_YEAR;
                end
            end
        end

        out_req_next.second_event  = sec_event;
        out_req_next.changed_field = changed;
        out_req_next.year_now      = year_next;
        out_req_next.month_now     = month_next;
        out_req_next.day_now       = day_next;
        out_req_next.hour_now      = hour_next;
        out_req_next.minute_now    = minute_next;
        out_req_next.second_now    = second_next;
        out_req_next.blink_led     = led_next;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_limit_reg <= PRESCALE_RESET;
        end
        else if (cfg_write_en)
        begin
            prescale_limit_reg <= cfg_write_data;
        end
    end

    // control: input and result valid flags, time state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tick_count_reg <= 8'd0;
            second_reg     <= SECOND_RESET;
            minute_reg     <= MINUTE_RESET;
            hour_reg       <= HOUR_RESET;
            day_reg        <= DAY_RESET;
            month_reg      <= MONTH_RESET;
            year_reg       <= YEAR_RESET;
            led_reg        <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                tick_count_reg <= tick_count_next;
                second_reg     <= second_next;
                minute_reg     <= minute_next;
                hour_reg       <= hour_next;
                day_reg        <= day_next;
                month_reg      <= month_next;
                year_reg       <= year_next;
                led_reg        <= led_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_req_reg <= in_req;
        end
        if (advance)
        begin
            out_req_reg <= out_req_next;
        end
    end

    // time fields never leave their legal ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        second_reg <= SECOND_MAX && minute_reg <= MINUTE_MAX &&
        hour_reg <= HOUR_MAX && year_reg <= YEAR_MAX &&
        month_reg >= MONTH_MIN && month_reg <= MONTH_MAX &&
        day_reg >= DAY_MIN && day_reg <= cur_len)
        else $error("time state out of range");

    // a change code is reported exactly when a second elapsed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        (out_req_reg.second_event == (out_req_reg.changed_field != CHG_NONE)))
        else $error("changed_field disagrees with second_event");

    // blink level flips on each processed second event and only then
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (led_reg != $past(led_reg)) == $past(sec_event))
        else $error("blink level out of step with second events");

    // a request held by a full result slot is kept until it drains
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg && $stable(in_req_reg))
        else $error("held input request lost");

    // the result slot only refills from a processed request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_free && !in_valid_reg |=> !out_valid_reg)
        else $error("result produced without a request");

endmodule

`default_nettype wire
